@@ rtl/mtm_pkg.sv @@
// Shared types, constants and note tables for the motor tone melody player.
package mtm_pkg;

    localparam logic [31:0] PHASE_GAIN_RESET = 32'd89594337;

    localparam int          FREQ_W      = 24;
    localparam logic [23:0] SWEEP_STEP  = 24'd10;
    localparam logic [23:0] FREQ_FLOOR  = 24'd10000;
    localparam logic [15:0] MAG_SWEEP   = 16'd19661;
    localparam logic [15:0] MAG_FULL    = 16'd32768;

    // Polynomial sine coefficients (Q14) and sqrt(3)/2 (Q15)
    localparam logic [15:0] SIN_A        = 16'd25736;
    localparam logic [15:0] SIN_B        = 16'd10512;
    localparam logic [15:0] SIN_C        = 16'd1160;
    localparam logic [15:0] SQRT3_HALF   = 16'd28378;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [15:0] HALF_TURN    = 16'd32768;
    localparam logic [15:0] THREE_QUARTER_TURN = 16'd49152;
    localparam logic [14:0] SIN_MAX      = 15'd32767;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PADD,
        ST_ANG,
        ST_M2,
        ST_T,
        ST_R,
        ST_S,
        ST_SC,
        ST_STORE,
        ST_K,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [15:0]       mag;
        logic              done;
    } tone_cmd_t;

    typedef struct packed {
        logic signed [15:0] phase_a;
        logic signed [15:0] phase_b;
        logic signed [15:0] phase_c;
        logic               completed;
    } tone_res_t;

    // Note frequency in centihertz; entries past the melody are silent
    function automatic logic [17:0] note_freq_chz(input logic [2:0] idx);
        logic [17:0] f;
        unique case (idx)
            3'd0:    f = 18'd104650;
            3'd1:    f = 18'd131851;
            3'd2:    f = 18'd156798;
            3'd4:    f = 18'd209300;
            default: f = 18'd0;
        endcase
        return f;
    endfunction

    // Note duration in milliseconds; entries past the melody last zero
    function automatic logic [9:0] note_len_ms(input logic [2:0] idx);
        logic [9:0] d;
        unique case (idx)
            3'd0:    d = 10'd200;
            3'd1:    d = 10'd200;
            3'd2:    d = 10'd200;
            3'd3:    d = 10'd300;
            3'd4:    d = 10'd600;
            default: d = 10'd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/mtm_ifs.sv @@
// Valid/ready channel interfaces for tick input, tone output and configuration.
interface mtm_tick_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] now_ms;

    modport source (output valid, output mode, output now_ms, input ready);
    modport sink (input valid, input mode, input now_ms, output ready);
endinterface

interface mtm_tone_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] phase_a;
    logic signed [15:0] phase_b;
    logic signed [15:0] phase_c;
    logic               completed;

    modport source (output valid, output phase_a, output phase_b, output phase_c,
                    output completed, input ready);
    modport sink (input valid, input phase_a, input phase_b, input phase_c,
                  input completed, output ready);
endinterface

interface mtm_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mtm_mul.sv @@
// Shared unsigned multiplier with registered product.
module mtm_mul
(
    input  logic        clk,
    input  logic [31:0] a_op,
    input  logic [23:0] b_op,
    output logic [55:0] prod
);

    logic [55:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {24'b0, a_op} * {32'b0, b_op};
    end

    assign prod = prod_reg;

endmodule

@@ rtl/mtm_note_seq.sv @@
// Melody and sweep sequencing: picks frequency, magnitude and done flag per tick.
module mtm_note_seq
#(
    parameter int NUM_NOTES = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                mode,
    input  logic [31:0]         now_ms,
    output mtm_pkg::tone_cmd_t  cmd
);

    localparam logic [2:0] LAST_STEP = 3'(NUM_NOTES + 1);

    logic [2:0]  step_reg, step_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [23:0] sweep_reg, sweep_next;
    logic [24:0] sweep_sum;
    logic [23:0] sweep_sat;

    assign sweep_sum = {1'b0, sweep_reg} + {1'b0, mtm_pkg::SWEEP_STEP};
    assign sweep_sat = sweep_sum[24] ? '1 : sweep_sum[23:0];

    always_comb
    begin
        step_next     = step_reg;
        deadline_next = deadline_reg;
        sweep_next    = sweep_reg;
        cmd           = '0;
        priority if (mode)
        begin
            sweep_next = sweep_sat;
            cmd.freq   = sweep_sat;
            cmd.mag    = mtm_pkg::MAG_SWEEP;
        end
        else if (step_reg == 3'd0)
        begin
            // silent first tick: arm the first note
            step_next     = 3'd1;
            deadline_next = now_ms + {22'b0, mtm_pkg::note_len_ms(3'd0)};
        end
        else if (step_reg >= LAST_STEP)
        begin
            cmd.done = 1'b1;
        end
        else
        begin
            cmd.freq = {6'b0, mtm_pkg::note_freq_chz(step_reg - 3'd1)};
            cmd.mag  = mtm_pkg::MAG_FULL;
            if (now_ms >= deadline_reg)
            begin
                step_next     = step_reg + 3'd1;
                deadline_next = now_ms + {22'b0, mtm_pkg::note_len_ms(step_reg)};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            deadline_reg <= '0;
            sweep_reg    <= '0;
        end
        else if (advance)
        begin
            step_reg     <= step_next;
            deadline_reg <= deadline_next;
            sweep_reg    <= sweep_next;
        end
    end

endmodule

@@ rtl/mtm_engine.sv @@
// Sequencer for phase accumulation, sin/cos and inverse Clarke on one multiplier.
module mtm_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        phase_gain,
    input  logic               start,
    input  mtm_pkg::tone_cmd_t cmd,
    input  logic               slot_free,
    output logic               idle,
    output logic               res_valid,
    output mtm_pkg::tone_res_t res
);

    mtm_pkg::state_t state_reg, state_next;

    logic [23:0]        freq_reg;
    logic [15:0]        mag_reg;
    logic               done_reg;
    logic [31:0]        phase_reg;
    logic               pass_sin_reg;
    logic [14:0]        m_reg;
    logic               neg_reg;
    logic [14:0]        m2_reg;
    logic [14:0]        am_reg, bm_reg;
    logic               sa_reg, sb_reg;
    logic signed [15:0] pa_reg, pb_reg, pc_reg;

    logic [31:0] mul_a;
    logic [23:0] mul_b;
    logic [55:0] prod;

    logic [15:0] angle;
    logic [14:0] m_z;
    logic        neg_z;
    logic [15:0] prod_q14;
    logic [15:0] res_raw;
    logic [14:0] res_clamp;
    logic [14:0] prod_q15;
    logic signed [17:0] alpha_s, half_s, k_s, pb_w, pc_w;

    mtm_mul u_mul
    (
        .clk  (clk),
        .a_op (mul_a),
        .b_op (mul_b),
        .prod (prod)
    );

    // cos pass first, using the angle advanced a quarter turn
    assign angle = phase_reg[31:16] + (pass_sin_reg ? 16'd0 : mtm_pkg::QUARTER_TURN);

    always_comb
    begin
        priority if (angle <= mtm_pkg::QUARTER_TURN)
        begin
            m_z   = angle[14:0];
            neg_z = 1'b0;
        end
        else if (angle <= mtm_pkg::THREE_QUARTER_TURN)
        begin
            if (angle > mtm_pkg::HALF_TURN)
            begin
                m_z   = 15'(angle - mtm_pkg::HALF_TURN);
                neg_z = 1'b1;
            end
            else
            begin
                m_z   = 15'(mtm_pkg::HALF_TURN - angle);
                neg_z = 1'b0;
            end
        end
        else
        begin
            m_z   = 15'(17'h10000 - {1'b0, angle});
            neg_z = 1'b1;
        end
    end

    assign prod_q14  = prod[29:14];
    assign res_raw   = prod[28:13];
    assign res_clamp = res_raw[15] ? mtm_pkg::SIN_MAX : res_raw[14:0];
    assign prod_q15  = prod[29:15];

    // Inverse Clarke, all magnitudes truncated toward zero
    always_comb
    begin
        alpha_s = sa_reg ? -$signed({3'b0, am_reg}) : $signed({3'b0, am_reg});
        half_s  = sa_reg ? -$signed({4'b0, am_reg[14:1]}) : $signed({4'b0, am_reg[14:1]});
        k_s     = sb_reg ? -$signed({3'b0, prod_q15}) : $signed({3'b0, prod_q15});
        pb_w    = k_s - half_s;
        pc_w    = -half_s - k_s;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtm_pkg::ST_IDLE:  if (start) state_next = mtm_pkg::ST_PMUL;
            mtm_pkg::ST_PMUL:  state_next = mtm_pkg::ST_PADD;
            mtm_pkg::ST_PADD:  state_next = (freq_reg > mtm_pkg::FREQ_FLOOR) ?
                                            mtm_pkg::ST_ANG : mtm_pkg::ST_OUT;
            mtm_pkg::ST_ANG:   state_next = mtm_pkg::ST_M2;
            mtm_pkg::ST_M2:    state_next = mtm_pkg::ST_T;
            mtm_pkg::ST_T:     state_next = mtm_pkg::ST_R;
            mtm_pkg::ST_R:     state_next = mtm_pkg::ST_S;
            mtm_pkg::ST_S:     state_next = mtm_pkg::ST_SC;
            mtm_pkg::ST_SC:    state_next = mtm_pkg::ST_STORE;
            mtm_pkg::ST_STORE: state_next = pass_sin_reg ? mtm_pkg::ST_K : mtm_pkg::ST_ANG;
            mtm_pkg::ST_K:     state_next = mtm_pkg::ST_FIN;
            mtm_pkg::ST_FIN:   state_next = mtm_pkg::ST_OUT;
            mtm_pkg::ST_OUT:   if (slot_free) state_next = mtm_pkg::ST_IDLE;
            default:           state_next = mtm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        idle      = 1'b0;
        res_valid = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            mtm_pkg::ST_IDLE: idle = 1'b1;
            mtm_pkg::ST_PMUL:
            begin
                mul_a = phase_gain;
                mul_b = freq_reg;
            end
            mtm_pkg::ST_M2:
            begin
                mul_a = {17'b0, m_reg};
                mul_b = {9'b0, m_reg};
            end
            mtm_pkg::ST_T:
            begin
                mul_a = {16'b0, mtm_pkg::SIN_C};
                mul_b = {8'b0, prod_q14};
            end
            mtm_pkg::ST_R:
            begin
                mul_a = {16'b0, mtm_pkg::SIN_B - prod_q14};
                mul_b = {9'b0, m2_reg};
            end
            mtm_pkg::ST_S:
            begin
                mul_a = {16'b0, mtm_pkg::SIN_A - prod_q14};
                mul_b = {9'b0, m_reg};
            end
            mtm_pkg::ST_SC:
            begin
                mul_a = {16'b0, mag_reg};
                mul_b = {9'b0, res_clamp};
            end
            mtm_pkg::ST_K:
            begin
                mul_a = {16'b0, mtm_pkg::SQRT3_HALF};
                mul_b = {9'b0, bm_reg};
            end
            mtm_pkg::ST_OUT: res_valid = 1'b1;
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtm_pkg::ST_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mtm_pkg::ST_PADD)
            begin
                phase_reg <= phase_reg + prod[47:16];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mtm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    freq_reg     <= cmd.freq;
                    mag_reg      <= cmd.mag;
                    done_reg     <= cmd.done;
                    pass_sin_reg <= 1'b0;
                end
            end
            mtm_pkg::ST_PADD:
            begin
                // silent tone: drop straight to a zero result
                pa_reg <= '0;
                pb_reg <= '0;
                pc_reg <= '0;
            end
            mtm_pkg::ST_ANG:
            begin
                m_reg   <= m_z;
                neg_reg <= neg_z;
            end
            mtm_pkg::ST_T: m2_reg <= prod_q14[14:0];
            mtm_pkg::ST_STORE:
            begin
                if (pass_sin_reg)
                begin
                    bm_reg <= prod_q15;
                    sb_reg <= neg_reg;
                end
                else
                begin
                    am_reg       <= prod_q15;
                    sa_reg       <= neg_reg;
                    pass_sin_reg <= 1'b1;
                end
            end
            mtm_pkg::ST_FIN:
            begin
                pa_reg <= alpha_s[15:0];
                pb_reg <= mtm_pkg::sat16(pb_w);
                pc_reg <= mtm_pkg::sat16(pc_w);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.phase_a   = pa_reg;
        res.phase_b   = pb_reg;
        res.phase_c   = pc_reg;
        res.completed = done_reg;
    end

endmodule

@@ rtl/motor_tone_melody_player_unit.sv @@
// Three-phase tone player: melody ROM or frequency sweep through DDS and inverse Clarke.
// A tick with a tone (frequency above 100 Hz) goes through all engine states; a silent tick
// skips from the phase update straight to the result. A new tick is taken only once the engine
// is idle again, after its result has moved to the output register; a tone's twelve
// products run in turn through the one shared multiplier.
// Reset: asynchronous active-low; melody, sweep and phase state clear, gain reloads.
module motor_tone_melody_player_unit
#(
    parameter int NUM_NOTES = 5
)
(
    input  logic            clk,
    input  logic            rst_n,
    mtm_tick_if.sink        tick,
    mtm_tone_if.source      tone,
    mtm_cfg_if.sink         cfg
);

    logic [31:0]        phase_gain_reg;
    logic               accept;
    logic               eng_idle;
    logic               res_valid;
    logic               slot_free;
    mtm_pkg::tone_cmd_t cmd;
    mtm_pkg::tone_res_t res;
    logic               tone_valid_reg;
    mtm_pkg::tone_res_t tone_res_reg;

    assign cfg.ready  = 1'b1;
    assign tick.ready = eng_idle;
    assign accept     = tick.valid & tick.ready;
    assign slot_free  = !tone_valid_reg || tone.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_gain_reg <= mtm_pkg::PHASE_GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            phase_gain_reg <= cfg.data;
        end
    end

    mtm_note_seq #(.NUM_NOTES(NUM_NOTES)) u_note_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .mode    (tick.mode),
        .now_ms  (tick.now_ms),
        .cmd     (cmd)
    );

    mtm_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .phase_gain (phase_gain_reg),
        .start      (accept),
        .cmd        (cmd),
        .slot_free  (slot_free),
        .idle       (eng_idle),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Output register: hold the beat until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_valid_reg <= 1'b0;
        end
        else if (res_valid && slot_free)
        begin
            tone_valid_reg <= 1'b1;
        end
        else if (tone.ready)
        begin
            tone_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && slot_free)
        begin
            tone_res_reg <= res;
        end
    end

    assign tone.valid     = tone_valid_reg;
    assign tone.phase_a   = tone_res_reg.phase_a;
    assign tone.phase_b   = tone_res_reg.phase_b;
    assign tone.phase_c   = tone_res_reg.phase_c;
    assign tone.completed = tone_res_reg.completed;

    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        tone.valid && tone.completed |->
            tone.phase_a == 16'sd0 && tone.phase_b == 16'sd0 && tone.phase_c == 16'sd0)
        else $error("finished melody produced a nonzero phase");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !tick.ready)
        else $error("input taken while the engine was busy");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !slot_free |=> res_valid && $stable(res))
        else $error("engine result changed before the output slot freed");

endmodule

@@ tb/sv/mtm_tone_compare.sv @@
`timescale 1ns / 1ps
// Predicts each tone beat from the accepted ticks and compares it with the block's output.
module mtm_tone_compare
(
    input  logic clk,
    input  logic rst_n,
    mtm_tick_if  tick_mon,
    mtm_tone_if  tone_mon,
    mtm_cfg_if   cfg_mon,
    output int   fail_count,
    output int   pending
);

    localparam int          NOTES       = 5;
    localparam int          MAG_SWEEP_Q = 19661;
    localparam int          MAG_FULL_Q  = 32768;
    localparam int          ROOT3_HALF  = 28378;
    localparam logic [23:0] SILENT_CHZ  = 24'd10000;
    localparam logic [23:0] SWEEP_MAX   = 24'hFFFFFF;
    localparam logic [24:0] SWEEP_INC   = 25'd10;
    localparam logic [15:0] QUARTER     = 16'd16384;

    logic [31:0]         phase_gain_q;
    logic [2:0]          melody_step;
    logic [31:0]         note_end;
    logic [31:0]         angle;
    logic [23:0]         sweep_chz;
    mtm_pkg::tone_res_t  tone_due [$];
    mtm_pkg::tone_res_t  want;
    int                  errs;

    function automatic logic [23:0] note_pitch(input logic [2:0] idx);
        logic [23:0] f;
        case (idx)
            3'd0:    f = 24'd104650;
            3'd1:    f = 24'd131851;
            3'd2:    f = 24'd156798;
            3'd4:    f = 24'd209300;
            default: f = 24'd0;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] note_dur(input logic [2:0] idx);
        logic [31:0] d;
        case (idx)
            3'd0:    d = 32'd200;
            3'd1:    d = 32'd200;
            3'd2:    d = 32'd200;
            3'd3:    d = 32'd300;
            3'd4:    d = 32'd600;
            default: d = 32'd0;
        endcase
        return d;
    endfunction

    // Odd polynomial in Q14, folded into the first quadrant
    function automatic int sine_of_angle(input logic [15:0] ang);
        int          v;
        int          z;
        int unsigned m;
        int unsigned m2;
        int unsigned r;
        int unsigned res;
        v = ang;
        if (ang <= 16'd16384)
        begin
            z = v;
        end
        else if (ang <= 16'd49152)
        begin
            z = 32768 - v;
        end
        else
        begin
            z = v - 65536;
        end
        m = (z < 0) ? -z : z;
        m2 = (m * m) >> 14;
        r = 32'd10512 - ((32'd1160 * m2) >> 14);
        r = (r * m2) >> 14;
        r = 32'd25736 - r;
        res = (m * r) >> 13;
        if (res > 32'd32767)
        begin
            res = 32'd32767;
        end
        return (z < 0) ? -int'(res) : int'(res);
    endfunction

    // Sign-magnitude Q15 product, truncated toward zero
    function automatic int q15_product(input int a, input int b);
        int unsigned ma;
        int unsigned mb;
        int          p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = int'((ma * mb) >> 15);
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic logic signed [15:0] clamp16(input int v);
        logic signed [15:0] r;
        if (v > 32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic mtm_pkg::tone_res_t tone_for_tick(input logic mode, input logic [31:0] now);
        logic [23:0]        freq;
        logic [24:0]        swept;
        logic [63:0]        prod;
        logic [15:0]        ang;
        int                 mag;
        int                 alpha;
        int                 beta;
        int                 half;
        int                 k;
        logic               done;
        mtm_pkg::tone_res_t r;
        freq = '0;
        mag = 0;
        done = 1'b0;
        if (mode)
        begin
            swept = {1'b0, sweep_chz} + SWEEP_INC;
            sweep_chz = swept[24] ? SWEEP_MAX : swept[23:0];
            freq = sweep_chz;
            mag = MAG_SWEEP_Q;
        end
        else if (melody_step == 3'd0)
        begin
            // first tick only arms the first note
            melody_step = 3'd1;
            note_end = now + note_dur(3'd0);
        end
        else if (melody_step >= NOTES + 1)
        begin
            done = 1'b1;
        end
        else
        begin
            freq = note_pitch(melody_step - 3'd1);
            mag = MAG_FULL_Q;
            if (now >= note_end)
            begin
                melody_step = melody_step + 3'd1;
                note_end = now + note_dur(melody_step - 3'd1);
            end
        end
        prod = 64'(freq) * 64'(phase_gain_q);
        angle = angle + prod[47:16];
        r = '0;
        if (freq > SILENT_CHZ)
        begin
            ang = angle[31:16];
            alpha = q15_product(mag, sine_of_angle(ang + QUARTER));
            beta = q15_product(mag, sine_of_angle(ang));
            half = alpha / 2;
            k = q15_product(ROOT3_HALF, beta);
            r.phase_a = clamp16(alpha);
            r.phase_b = clamp16(-half + k);
            r.phase_c = clamp16(-half - k);
        end
        r.completed = done;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_gain_q = mtm_pkg::PHASE_GAIN_RESET;
            melody_step = '0;
            note_end = '0;
            angle = '0;
            sweep_chz = '0;
            tone_due.delete();
            errs = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (tone_mon.valid && tone_mon.ready)
            begin
                if (tone_due.size() == 0)
                begin
                    $error("tone beat with no tick waiting");
                    errs++;
                end
                else
                begin
                    want = tone_due.pop_front();
                    if (tone_mon.phase_a !== want.phase_a)
                    begin
                        $error("phase_a: expected %0d, got %0d", want.phase_a, tone_mon.phase_a);
                        errs++;
                    end
                    if (tone_mon.phase_b !== want.phase_b)
                    begin
                        $error("phase_b: expected %0d, got %0d", want.phase_b, tone_mon.phase_b);
                        errs++;
                    end
                    if (tone_mon.phase_c !== want.phase_c)
                    begin
                        $error("phase_c: expected %0d, got %0d", want.phase_c, tone_mon.phase_c);
                        errs++;
                    end
                    if (tone_mon.completed !== want.completed)
                    begin
                        $error("completed: expected %0d, got %0d",
                               want.completed, tone_mon.completed);
                        errs++;
                    end
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                phase_gain_q = cfg_mon.data;
            end
            if (tick_mon.valid && tick_mon.ready)
            begin
                tone_due.push_back(tone_for_tick(tick_mon.mode, tick_mon.now_ms));
            end
            fail_count <= errs;
            pending <= tone_due.size();
        end
    end

endmodule

@@ tb/sv/tb_motor_tone_melody_player_unit.sv @@
`timescale 1ns / 1ps
// Top of the tone player bench: clock, reset, tick and gain stimulus, output stalls and verdict.
module tb_motor_tone_melody_player_unit;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 130;

    logic        clk;
    logic        rst_n;
    int          fails;
    int          pending;
    bit          calm;
    logic [31:0] melody_ms;
    int          tone_beats;
    int          stall_left;
    bit          held;
    int          idle_cycles;

    mtm_tick_if tick_ch ();
    mtm_tone_if tone_ch ();
    mtm_cfg_if  cfg_ch ();

    motor_tone_melody_player_unit #(
        .NUM_NOTES (5)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .tone  (tone_ch),
        .cfg   (cfg_ch)
    );

    mtm_tone_compare tone_cmp (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_mon   (tick_ch),
        .tone_mon   (tone_ch),
        .cfg_mon    (cfg_ch),
        .fail_count (fails),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic offer_tick(input logic m, input logic [31:0] t);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.mode <= m;
        tick_ch.now_ms <= t;
        @(posedge clk);
        while (!tick_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Hold the sender until every predicted beat is out, then let the pipe settle
    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (25) @(posedge clk);
    endtask

    task automatic write_gain(input logic [31:0] g);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= g;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Half sweep ticks, half melody ticks on a mostly steady millisecond clock
    task automatic run_phase(input int count, input bit pause_mid);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
            begin
                drain();
            end
            if ($urandom_range(0, 1) == 1)
            begin
                offer_tick(1'b1, $urandom());
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                begin
                    melody_ms = melody_ms + $urandom_range(0, 400);
                end
                else
                begin
                    melody_ms = melody_ms + $urandom_range(0, 6);
                end
                if (roll >= 96)
                begin
                    // late time stamp, clock itself keeps going
                    offer_tick(1'b0, melody_ms - $urandom_range(1, 20));
                end
                else
                begin
                    offer_tick(1'b0, melody_ms);
                end
            end
        end
    endtask

    initial
    begin
        tick_ch.valid <= 1'b0;
        tick_ch.mode <= 1'b0;
        tick_ch.now_ms <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        rst_n <= 1'b0;
        calm = 1'b0;
        melody_ms = 32'd500;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Deadline wraps past the top of the time range, then equality advances a note
        offer_tick(1'b0, 32'hFFFF_FF80);
        offer_tick(1'b0, 32'h0000_0000);
        offer_tick(1'b0, 32'hFFFF_FFFF);
        offer_tick(1'b1, 32'h0000_0000);
        offer_tick(1'b1, 32'hFFFF_FFFF);
        offer_tick(1'b0, 32'd100);
        offer_tick(1'b0, 32'd199);
        drain();
        write_gain(32'hFFFF_FFFF);
        offer_tick(1'b0, 32'd250);
        offer_tick(1'b1, 32'h5A5A_5A5A);
        offer_tick(1'b0, 32'd399);
        // silent note: zero frequency while the melody still plays
        offer_tick(1'b0, 32'd400);
        drain();
        write_gain(32'h0000_0000);
        offer_tick(1'b0, 32'd500);
        offer_tick(1'b1, 32'd1);
        drain();
        write_gain(mtm_pkg::PHASE_GAIN_RESET);

        run_phase(PHASE_ITEMS, 1'b0);
        drain();
        write_gain($urandom());
        calm = 1'b1;
        run_phase(PHASE_ITEMS, 1'b0);
        calm = 1'b0;
        drain();
        write_gain(32'hFFFF_FFFF);
        run_phase(PHASE_ITEMS, 1'b1);
        drain();
        write_gain(32'h0000_0000);
        run_phase(PHASE_ITEMS, 1'b0);
        drain();
        write_gain($urandom_range(1, 1000));
        run_phase(PHASE_ITEMS, 1'b0);
        drain();

        if (fails == 0 && pending == 0)
        begin
            $display("tb_motor_tone_melody_player_unit: clean");
        end
        else
        begin
            $display("tb_motor_tone_melody_player_unit: errors");
        end
        $finish;
    end

    // Output side: random stalls, one long hold-off, one stretch always ready
    initial
    begin
        tone_beats = 0;
        stall_left = 0;
        held = 1'b0;
        tone_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (tone_ch.valid && tone_ch.ready)
            begin
                tone_beats++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                tone_ch.ready <= 1'b0;
            end
            else if (!held && tone_beats >= 80)
            begin
                held = 1'b1;
                stall_left = 399;
                tone_ch.ready <= 1'b0;
            end
            else if (tone_beats >= 300 && tone_beats < 360)
            begin
                tone_ch.ready <= 1'b1;
            end
            else
            begin
                tone_ch.ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Abort when no channel moves a beat for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((tick_ch.valid && tick_ch.ready) || (tone_ch.valid && tone_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("tb_motor_tone_melody_player_unit: errors");
        $finish;
    end

endmodule
